>>> rtl/core/vvhs_pkg.sv
package vvhs_pkg;

   // Word widths
   localparam int DW     = 32;            // Q16.16 values and Q8.24 step scales
   localparam int PW     = 2 * DW;        // full product width
   localparam int KSHIFT = 8;             // Q8.24 * Q16.16 over Q16.16 mass -> 40 fraction bits
   localparam int DVW    = DW + KSHIFT;   // divisor width: mass << 8
   localparam int QW     = 36;            // quotient bits kept; larger quotients clamp
   localparam int BPS    = 3;             // quotient bits resolved per divider stage
   localparam int NDIV   = QW / BPS;      // divider stages
   localparam int DFRAC  = 24;            // fraction bits dropped after the drift product
   localparam int DQW    = PW - DFRAC;    // drift step magnitude width
   localparam int SATW   = 42;            // signed width ahead of saturation
   localparam int NAXIS  = 3;

   // Particle types
   localparam int NUM_TYPES  = 4;
   localparam int MASS_REGS  = 4;
   localparam int MIDX_W     = $clog2(MASS_REGS);
   localparam int TYPE_W     = 3;
   localparam int TYPE_LIMIT = (NUM_TYPES < MASS_REGS) ? NUM_TYPES : MASS_REGS;

   // Pipeline stage numbers: stage k is the k-th register that a request passes through
   localparam int STG_IN    = 1;                 // magnitudes, divisor
   localparam int STG_MUL   = 2;                 // force times kick scale
   localparam int STG_ADD   = 3;                 // rounding offset added
   localparam int STG_PRE   = 4;                 // overflow check, remainder seed
   localparam int STG_QUO   = STG_PRE + NDIV;    // quotient complete
   localparam int STG_KICK  = STG_QUO + 1;       // new velocity
   localparam int STG_DMUL  = STG_KICK + 1;      // velocity times drift step
   localparam int STG_RND   = STG_DMUL + 1;      // drift step rounded
   localparam int STG_DRIFT = STG_RND + 1;       // new position
   localparam int STG_MERGE = STG_DRIFT + 1;     // lanes merged into one result

   // Register file
   localparam int CSR_AW    = 5;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_DRIFT_STEP   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KICK_SCALE   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GROUP_SELECT = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MASS_ONE     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MASS_TWO     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MASS_THREE   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MASS_FOUR    = 3'd6;

   localparam logic [DW-1:0] RST_DRIFT_STEP   = 32'd16777;
   localparam logic [DW-1:0] RST_KICK_SCALE   = 32'd8388608;
   localparam logic [DW-1:0] RST_GROUP_SELECT = 32'd1;
   localparam logic [DW-1:0] RST_MASS         = 32'd65536;

   localparam logic [DW-1:0] SAT_MAX    = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_MIN    = {1'b1, {(DW-1){1'b0}}};
   localparam logic [PW-1:0] DRIFT_HALF = PW'(1) << (DFRAC - 1);

   typedef struct packed {
      logic [DW-1:0]                 drift_step;
      logic [DW-1:0]                 kick_scale;
      logic [DW-1:0]                 group_select;
      logic [MASS_REGS-1:0][DW-1:0]  mass;
   } cfg_type;

   typedef struct packed {
      logic func;
      logic applied;
   } side_type;

   typedef struct packed {
      logic [DW-1:0] vel;
      logic [DW-1:0] pos;
      logic [DW-1:0] new_vel;
      logic [DW-1:0] new_pos;
      logic          clip_vel;
      logic          clip_pos;
   } lane_out_type;

   typedef struct packed {
      logic [NAXIS-1:0][DW-1:0] vel;
      logic [NAXIS-1:0][DW-1:0] pos;
      logic                     applied;
      logic                     saturated;
   } result_type;

   typedef struct packed {
      logic [DVW-1:0] rem;
      logic [QW-1:0]  ql;
   } div_type;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          clip;
   } sat_type;

   // Restoring division, BPS quotient bits. ql holds the unused dividend bits
   // at the top and collects quotient bits at the bottom.
   function automatic div_type div_step(input logic [DVW-1:0] rem,
                                        input logic [QW-1:0]  ql,
                                        input logic [DVW-1:0] divisor);
      logic [DVW:0]   trial;
      logic [DVW-1:0] r;
      logic [QW-1:0]  q;
      div_type        res;
      r = rem;
      q = ql;
      for (int i = 0; i < BPS; i++) begin
         trial = {r, q[QW-1]};
         q     = {q[QW-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            q[0]  = 1'b1;
         end
         r = trial[DVW-1:0];
      end
      res.rem = r;
      res.ql  = q;
      return res;
   endfunction

   // Clip a wide two's complement sum to signed Q16.16
   function automatic sat_type sat_word(input logic [SATW-1:0] sum);
      sat_type res;
      if (!sum[SATW-1] && (|sum[SATW-2:DW-1])) begin
         res.val  = SAT_MAX;
         res.clip = 1'b1;
      end else if (sum[SATW-1] && !(&sum[SATW-2:DW-1])) begin
         res.val  = SAT_MIN;
         res.clip = 1'b1;
      end else begin
         res.val  = sum[DW-1:0];
         res.clip = 1'b0;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/vvhs_ctrl.sv
module vvhs_ctrl (
   input  logic                                                      clock,
   input  logic                                                      reset,
   input  logic                                                      en,
   input  logic                                                      in_valid,
   input  logic                                                      in_func,
   input  logic [vvhs_pkg::DW-1:0]                                   in_mask,
   input  logic [vvhs_pkg::TYPE_W-1:0]                               in_type,
   input  vvhs_pkg::cfg_type                                         cfg,
   output logic [vvhs_pkg::STG_QUO-1:vvhs_pkg::STG_IN][vvhs_pkg::DVW-1:0] stage_div,
   output vvhs_pkg::side_type                                        tail_side,
   output logic                                                      tail_valid
);

   logic [vvhs_pkg::STG_MERGE:vvhs_pkg::STG_IN]                      valid_ff;
   vvhs_pkg::side_type [vvhs_pkg::STG_DRIFT:vvhs_pkg::STG_IN]        side_ff;
   logic [vvhs_pkg::STG_QUO-1:vvhs_pkg::STG_IN][vvhs_pkg::DVW-1:0]   div_ff;

   logic                              type_ok;
   logic [vvhs_pkg::MIDX_W-1:0]       midx;
   logic [vvhs_pkg::DW-1:0]           mass_sel;
   logic [vvhs_pkg::DW-1:0]           mass_nz;
   logic [vvhs_pkg::DVW-1:0]          div_in;
   vvhs_pkg::side_type                side_in;

   // Decide group membership and pick the divisor for this request
   always_comb begin
      type_ok  = (in_type >= vvhs_pkg::TYPE_W'(1)) &&
                 (in_type <= vvhs_pkg::TYPE_W'(vvhs_pkg::TYPE_LIMIT));
      midx     = vvhs_pkg::MIDX_W'(in_type - vvhs_pkg::TYPE_W'(1));
      mass_sel = cfg.mass[midx];
      // a zero mass acts as the smallest nonzero mass
      mass_nz  = (mass_sel == '0) ? vvhs_pkg::DW'(1) : mass_sel;
      div_in   = {mass_nz, vvhs_pkg::KSHIFT'(0)};
      side_in.func    = in_func;
      side_in.applied = (|(in_mask & cfg.group_select)) && type_ok;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[vvhs_pkg::STG_MERGE-1:vvhs_pkg::STG_IN], in_valid};
      end
   end

   // Advance sideband and divisor alongside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= {side_ff[vvhs_pkg::STG_DRIFT-1:vvhs_pkg::STG_IN], side_in};
         div_ff  <= {div_ff[vvhs_pkg::STG_QUO-2:vvhs_pkg::STG_IN], div_in};
      end
   end

   assign stage_div  = div_ff;
   assign tail_side  = side_ff[vvhs_pkg::STG_DRIFT];
   assign tail_valid = valid_ff[vvhs_pkg::STG_MERGE];

endmodule

>>> rtl/core/vvhs_lane.sv
module vvhs_lane (
   input  logic                                                      clock,
   input  logic                                                      en,
   input  logic [vvhs_pkg::DW-1:0]                                   kick_scale,
   input  logic [vvhs_pkg::DW-1:0]                                   drift_step,
   input  logic [vvhs_pkg::DW-1:0]                                   force_val,
   input  logic [vvhs_pkg::DW-1:0]                                   vel_val,
   input  logic [vvhs_pkg::DW-1:0]                                   pos_val,
   input  logic [vvhs_pkg::STG_QUO-1:vvhs_pkg::STG_IN][vvhs_pkg::DVW-1:0] stage_div,
   output vvhs_pkg::lane_out_type                                    lane_res
);

   logic [vvhs_pkg::DW-1:0]                                          fmag_ff;
   logic [vvhs_pkg::STG_QUO:vvhs_pkg::STG_IN]                        fneg_ff;
   logic [vvhs_pkg::STG_DRIFT:vvhs_pkg::STG_IN][vvhs_pkg::DW-1:0]    v_ff;
   logic [vvhs_pkg::STG_DRIFT:vvhs_pkg::STG_IN][vvhs_pkg::DW-1:0]    x_ff;
   logic [vvhs_pkg::PW-1:0]                                          p_ff;
   logic [vvhs_pkg::PW-1:0]                                          n_ff;
   logic [vvhs_pkg::DVW-1:0]  rem_ff [vvhs_pkg::STG_PRE:vvhs_pkg::STG_QUO-1];
   logic [vvhs_pkg::QW-1:0]   ql_ff  [vvhs_pkg::STG_PRE:vvhs_pkg::STG_QUO];
   logic [vvhs_pkg::STG_QUO:vvhs_pkg::STG_PRE]                       ovf_ff;
   logic [vvhs_pkg::STG_DRIFT:vvhs_pkg::STG_KICK][vvhs_pkg::DW-1:0]  nv_ff;
   logic [vvhs_pkg::STG_DRIFT:vvhs_pkg::STG_KICK]                    clipv_ff;
   logic [vvhs_pkg::PW-1:0]                                          dp_ff;
   logic [vvhs_pkg::DQW-1:0]                                         dq_ff;
   logic [vvhs_pkg::DW-1:0]                                          nx_ff;
   logic                                                             clipx_ff;

   logic [vvhs_pkg::DW-1:0]   fmag_in;
   logic                      ovf_in;
   vvhs_pkg::div_type         div_res [vvhs_pkg::STG_PRE:vvhs_pkg::STG_QUO-1];
   logic [vvhs_pkg::QW:0]     dmag;
   logic [vvhs_pkg::SATW-1:0] kick_d;
   logic [vvhs_pkg::SATW-1:0] kick_v;
   vvhs_pkg::sat_type         kick_in;
   logic [vvhs_pkg::DW-1:0]   vmag_in;
   logic [vvhs_pkg::PW-1:0]   rnd_in;
   logic [vvhs_pkg::SATW-1:0] drift_d;
   logic [vvhs_pkg::SATW-1:0] drift_x;
   vvhs_pkg::sat_type         drift_in;

   // Front end: force magnitude, overflow of the quotient
   always_comb begin
      fmag_in = force_val[vvhs_pkg::DW-1] ? (~force_val + 1'b1) : force_val;
      ovf_in  = {(vvhs_pkg::DVW - (vvhs_pkg::PW - vvhs_pkg::QW))'(0),
                 n_ff[vvhs_pkg::PW-1:vvhs_pkg::QW]} >= stage_div[vvhs_pkg::STG_ADD];
   end

   // Divider stages
   always_comb begin
      for (int k = vvhs_pkg::STG_PRE; k < vvhs_pkg::STG_QUO; k++) begin
         div_res[k] = vvhs_pkg::div_step(rem_ff[k], ql_ff[k], stage_div[k]);
      end
   end

   // Kick: v + round(kick_scale * f / mass), saturated
   always_comb begin
      dmag   = ovf_ff[vvhs_pkg::STG_QUO] ? {1'b1, vvhs_pkg::QW'(0)}
                                         : {1'b0, ql_ff[vvhs_pkg::STG_QUO]};
      kick_d = vvhs_pkg::SATW'(dmag);
      if (fneg_ff[vvhs_pkg::STG_QUO]) begin
         kick_d = -kick_d;
      end
      kick_v  = {{(vvhs_pkg::SATW - vvhs_pkg::DW){v_ff[vvhs_pkg::STG_QUO][vvhs_pkg::DW-1]}},
                 v_ff[vvhs_pkg::STG_QUO]};
      kick_in = vvhs_pkg::sat_word(kick_v + kick_d);
   end

   // Drift: x + round(drift_step * v'), saturated
   always_comb begin
      vmag_in = nv_ff[vvhs_pkg::STG_KICK][vvhs_pkg::DW-1] ? (~nv_ff[vvhs_pkg::STG_KICK] + 1'b1)
                                                          : nv_ff[vvhs_pkg::STG_KICK];
      rnd_in  = dp_ff + vvhs_pkg::DRIFT_HALF;
      drift_d = vvhs_pkg::SATW'(dq_ff);
      if (nv_ff[vvhs_pkg::STG_RND][vvhs_pkg::DW-1]) begin
         drift_d = -drift_d;
      end
      drift_x  = {{(vvhs_pkg::SATW - vvhs_pkg::DW){x_ff[vvhs_pkg::STG_RND][vvhs_pkg::DW-1]}},
                  x_ff[vvhs_pkg::STG_RND]};
      drift_in = vvhs_pkg::sat_word(drift_x + drift_d);
   end

   // Advance all lane stages together
   always_ff @(posedge clock) begin
      if (en) begin
         fmag_ff <= fmag_in;
         fneg_ff <= {fneg_ff[vvhs_pkg::STG_QUO-1:vvhs_pkg::STG_IN], force_val[vvhs_pkg::DW-1]};
         v_ff    <= {v_ff[vvhs_pkg::STG_DRIFT-1:vvhs_pkg::STG_IN], vel_val};
         x_ff    <= {x_ff[vvhs_pkg::STG_DRIFT-1:vvhs_pkg::STG_IN], pos_val};

         p_ff <= vvhs_pkg::PW'(fmag_ff) * vvhs_pkg::PW'(kick_scale);
         n_ff <= p_ff + vvhs_pkg::PW'(stage_div[vvhs_pkg::STG_MUL] >> 1);

         rem_ff[vvhs_pkg::STG_PRE] <= vvhs_pkg::DVW'(n_ff[vvhs_pkg::PW-1:vvhs_pkg::QW]);
         ql_ff[vvhs_pkg::STG_PRE]  <= n_ff[vvhs_pkg::QW-1:0];
         ovf_ff <= {ovf_ff[vvhs_pkg::STG_QUO-1:vvhs_pkg::STG_PRE], ovf_in};
         for (int k = vvhs_pkg::STG_PRE + 1; k < vvhs_pkg::STG_QUO; k++) begin
            rem_ff[k] <= div_res[k-1].rem;
         end
         for (int k = vvhs_pkg::STG_PRE + 1; k <= vvhs_pkg::STG_QUO; k++) begin
            ql_ff[k] <= div_res[k-1].ql;
         end

         nv_ff    <= {nv_ff[vvhs_pkg::STG_DRIFT-1:vvhs_pkg::STG_KICK], kick_in.val};
         clipv_ff <= {clipv_ff[vvhs_pkg::STG_DRIFT-1:vvhs_pkg::STG_KICK], kick_in.clip};

         dp_ff    <= vvhs_pkg::PW'(vmag_in) * vvhs_pkg::PW'(drift_step);
         dq_ff    <= rnd_in[vvhs_pkg::PW-1:vvhs_pkg::DFRAC];
         nx_ff    <= drift_in.val;
         clipx_ff <= drift_in.clip;
      end
   end

   always_comb begin
      lane_res.vel      = v_ff[vvhs_pkg::STG_DRIFT];
      lane_res.pos      = x_ff[vvhs_pkg::STG_DRIFT];
      lane_res.new_vel  = nv_ff[vvhs_pkg::STG_DRIFT];
      lane_res.new_pos  = nx_ff;
      lane_res.clip_vel = clipv_ff[vvhs_pkg::STG_DRIFT];
      lane_res.clip_pos = clipx_ff;
   end

endmodule

>>> rtl/core/vvhs_merge.sv
module vvhs_merge (
   input  logic                                           clock,
   input  logic                                           en,
   input  vvhs_pkg::side_type                             side,
   input  vvhs_pkg::lane_out_type [vvhs_pkg::NAXIS-1:0]   lanes,
   output vvhs_pkg::result_type                           result
);

   vvhs_pkg::result_type result_ff;
   vvhs_pkg::result_type result_in;
   logic                 clip_any;

   // Pick updated or passed values and fold the clip flags
   always_comb begin
      clip_any = 1'b0;
      for (int i = 0; i < vvhs_pkg::NAXIS; i++) begin
         result_in.vel[i] = side.applied ? lanes[i].new_vel : lanes[i].vel;
         result_in.pos[i] = (side.applied && !side.func) ? lanes[i].new_pos : lanes[i].pos;
         clip_any = clip_any | lanes[i].clip_vel | (!side.func & lanes[i].clip_pos);
      end
      result_in.applied   = side.applied;
      result_in.saturated = side.applied & clip_any;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/core/velocity_verlet_half_step.sv
// Velocity Verlet half step, one particle per request.
// Request channel (req_valid/req_ready): phase, group mask, type, and the
// force, velocity and position vectors in signed Q16.16. Response channel
// (rsp_valid/rsp_ready): new velocity and position, applied and saturated.
// Registers sit on an APB-style port (psel/penable/pwrite/paddr/pwdata,
// prdata, pready tied high), one 32-bit register every 4 bytes: drift step,
// kick scale, group select, then the masses of types one to four. Write them
// only while no request is in flight.
// Throughput is one request per cycle while the skid register is empty.
// Three axis lanes run side by side; each holds a 32x32 product, a
// 12-stage restoring divider (3 quotient bits a stage) for the mass, and a
// second product for the drift. A merge stage builds the result.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// When the receiver stalls, a skid register takes one more result, and then
// req_ready drops and the whole pipeline holds until the skid drains.
module velocity_verlet_half_step (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [31:0]                           req_member_mask,
   input  logic [vvhs_pkg::TYPE_W-1:0]           req_particle_type,
   input  logic signed [31:0]                    req_force_x,
   input  logic signed [31:0]                    req_force_y,
   input  logic signed [31:0]                    req_force_z,
   input  logic signed [31:0]                    req_vel_x,
   input  logic signed [31:0]                    req_vel_y,
   input  logic signed [31:0]                    req_vel_z,
   input  logic signed [31:0]                    req_pos_x,
   input  logic signed [31:0]                    req_pos_y,
   input  logic signed [31:0]                    req_pos_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [31:0]                    rsp_new_vel_x,
   output logic signed [31:0]                    rsp_new_vel_y,
   output logic signed [31:0]                    rsp_new_vel_z,
   output logic signed [31:0]                    rsp_new_pos_x,
   output logic signed [31:0]                    rsp_new_pos_y,
   output logic signed [31:0]                    rsp_new_pos_z,
   output logic                                  rsp_applied,
   output logic                                  rsp_saturated,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [vvhs_pkg::CSR_AW-1:0]           paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   vvhs_pkg::cfg_type     cfg_ff;
   vvhs_pkg::result_type  out_ff;
   logic                  out_valid_ff;
   vvhs_pkg::result_type  skid_ff;
   logic                  skid_valid_ff;

   logic                                  en;
   logic                                  csr_wr;
   logic [vvhs_pkg::REG_IDX_W-1:0]        reg_idx;
   logic                                  pop;
   logic                                  push;
   logic                                  tail_valid;
   vvhs_pkg::side_type                    tail_side;
   vvhs_pkg::result_type                  tail_res;
   logic [vvhs_pkg::STG_QUO-1:vvhs_pkg::STG_IN][vvhs_pkg::DVW-1:0] stage_div;
   vvhs_pkg::lane_out_type [vvhs_pkg::NAXIS-1:0]                    lanes;
   logic [vvhs_pkg::NAXIS-1:0][vvhs_pkg::DW-1:0] force_vec;
   logic [vvhs_pkg::NAXIS-1:0][vvhs_pkg::DW-1:0] vel_vec;
   logic [vvhs_pkg::NAXIS-1:0][vvhs_pkg::DW-1:0] pos_vec;

   // Pipeline moves whenever the skid stage is empty
   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign pop       = out_valid_ff & rsp_ready;
   assign push      = en & tail_valid;

   assign csr_wr  = psel & penable & pwrite & pready;
   assign reg_idx = paddr[vvhs_pkg::CSR_AW-1:2];
   assign pready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drift_step   <= vvhs_pkg::RST_DRIFT_STEP;
         cfg_ff.kick_scale   <= vvhs_pkg::RST_KICK_SCALE;
         cfg_ff.group_select <= vvhs_pkg::RST_GROUP_SELECT;
         cfg_ff.mass         <= {vvhs_pkg::MASS_REGS{vvhs_pkg::RST_MASS}};
      end else if (csr_wr) begin
         case (reg_idx)
            vvhs_pkg::REG_DRIFT_STEP:   cfg_ff.drift_step   <= pwdata;
            vvhs_pkg::REG_KICK_SCALE:   cfg_ff.kick_scale   <= pwdata;
            vvhs_pkg::REG_GROUP_SELECT: cfg_ff.group_select <= pwdata;
            vvhs_pkg::REG_MASS_ONE:     cfg_ff.mass[0]      <= pwdata;
            vvhs_pkg::REG_MASS_TWO:     cfg_ff.mass[1]      <= pwdata;
            vvhs_pkg::REG_MASS_THREE:   cfg_ff.mass[2]      <= pwdata;
            vvhs_pkg::REG_MASS_FOUR:    cfg_ff.mass[3]      <= pwdata;
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (reg_idx)
         vvhs_pkg::REG_DRIFT_STEP:   prdata = cfg_ff.drift_step;
         vvhs_pkg::REG_KICK_SCALE:   prdata = cfg_ff.kick_scale;
         vvhs_pkg::REG_GROUP_SELECT: prdata = cfg_ff.group_select;
         vvhs_pkg::REG_MASS_ONE:     prdata = cfg_ff.mass[0];
         vvhs_pkg::REG_MASS_TWO:     prdata = cfg_ff.mass[1];
         vvhs_pkg::REG_MASS_THREE:   prdata = cfg_ff.mass[2];
         vvhs_pkg::REG_MASS_FOUR:    prdata = cfg_ff.mass[3];
         default:                    prdata = '0;
      endcase
   end

   vvhs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .in_func    (req_func),
      .in_mask    (req_member_mask),
      .in_type    (req_particle_type),
      .cfg        (cfg_ff),
      .stage_div  (stage_div),
      .tail_side  (tail_side),
      .tail_valid (tail_valid)
   );

   assign force_vec = {req_force_z, req_force_y, req_force_x};
   assign vel_vec   = {req_vel_z, req_vel_y, req_vel_x};
   assign pos_vec   = {req_pos_z, req_pos_y, req_pos_x};

   // One lane per axis
   for (genvar a = 0; a < vvhs_pkg::NAXIS; a++) begin : g_lane
      vvhs_lane u_lane (
         .clock      (clock),
         .en         (en),
         .kick_scale (cfg_ff.kick_scale),
         .drift_step (cfg_ff.drift_step),
         .force_val  (force_vec[a]),
         .vel_val    (vel_vec[a]),
         .pos_val    (pos_vec[a]),
         .stage_div  (stage_div),
         .lane_res   (lanes[a])
      );
   end

   vvhs_merge u_merge (
      .clock  (clock),
      .en     (en),
      .side   (tail_side),
      .lanes  (lanes),
      .result (tail_res)
   );

   // Output register with skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= tail_res;
         end else begin
            skid_ff <= tail_res;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_new_vel_x = out_ff.vel[0];
   assign rsp_new_vel_y = out_ff.vel[1];
   assign rsp_new_vel_z = out_ff.vel[2];
   assign rsp_new_pos_x = out_ff.pos[0];
   assign rsp_new_pos_y = out_ff.pos[1];
   assign rsp_new_pos_z = out_ff.pos[2];
   assign rsp_applied   = out_ff.applied;
   assign rsp_saturated = out_ff.saturated;

   // A full skid stage always sits behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   // A stalled output with a result arriving fills the skid stage
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("result arrived at stalled output but skid stage stayed empty");

   // Clipping is only reported for updated particles
   a_sat_applied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> rsp_applied)
      else $error("saturated reported on a particle that was not updated");

   // No request is taken while the skid stage holds a result
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req_ready)
      else $error("request accepted while skid stage full");

endmodule
